[hdl/held_lock_order_checker_defines.svh]
// Assertion macros shared by the held lock order checker modules.
`ifndef HELD_LOCK_ORDER_CHECKER_DEFINES_SVH
`define HELD_LOCK_ORDER_CHECKER_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define HLOC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define HLOC_ASSERT_IMPL(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define HLOC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hloc_pkg.sv]
// Shared types, widths and codes of the held lock order checker.
`timescale 1ns / 1ps

package hloc_pkg;

  // Default sizes of the lock stacks
  localparam int unsigned MAX_HELD_DEF = 16;
  localparam int unsigned TASKS_DEF    = 16;

  // Field widths
  localparam int unsigned TASK_ID_W   = 4;
  localparam int unsigned LOCK_W      = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_OUT_W = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd5;

  // Mode codes
  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Classified item as queued for the back end
  typedef struct packed {
    logic                 ignored;
    logic                 mode;
    logic [TASK_ID_W-1:0] task_id;
    logic [LOCK_W-1:0]    lock_id;
  } hloc_item_t;

endpackage

[hdl/hloc_front.sv]
// Front end: accepts input transactions, holds the enable register, classifies items.
`timescale 1ns / 1ps

module hloc_front import hloc_pkg::*; #(
  parameter int unsigned TASKS = TASKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: task_id[3:0], task_valid[4], lock_id[36:5], tracked[37], zero pad[39:38]
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: mode[0]
  input  logic                  s_axis_tuser_i,
  // configuration write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i,
  // queue push side
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output hloc_item_t            q_item_o
);

  logic                 check_en_q;
  logic                 check_en_d;
  logic [TASK_ID_W-1:0] task_id;
  logic                 task_valid;
  logic                 tracked;
  logic                 task_in_range;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;
  assign check_en_d  = cfg_valid_i ? cfg_data_i : check_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q <= 1'b0;
    end else begin
      check_en_q <= check_en_d;
    end
  end

  // Unpack the fields
  assign task_id    = s_axis_tdata_i[3:0];
  assign task_valid = s_axis_tdata_i[4];
  assign tracked    = s_axis_tdata_i[37];

  assign task_in_range = (32'(task_id) < TASKS);

  // Classify and push when the queue has room
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_item_o         = '0;
    q_item_o.ignored = !check_en_q || !tracked || !task_valid || !task_in_range;
    q_item_o.mode    = s_axis_tuser_i;
    q_item_o.task_id = task_id;
    q_item_o.lock_id = s_axis_tdata_i[36:5];
  end

endmodule

[hdl/hloc_fifo.sv]
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps

module hloc_fifo import hloc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hloc_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output hloc_item_t item_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  hloc_item_t       slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/hloc_back.sv]
// Back end: sequencer over the depth and stack memories, result register.
`timescale 1ns / 1ps
`include "held_lock_order_checker_defines.svh"

module hloc_back import hloc_pkg::*; #(
  parameter int unsigned MAX_HELD = MAX_HELD_DEF,
  parameter int unsigned TASKS    = TASKS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // queue pop side
  input  logic                   q_valid_i,
  input  hloc_item_t             q_item_i,
  output logic                   q_pop_o,
  // result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: status[2:0], depth_after[7:3], expected_lock[39:8]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned SLOTS = TASKS * MAX_HELD;
  localparam int unsigned SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TW    = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned DW    = $clog2(MAX_HELD + 1);
  localparam int unsigned DW1   = DW + 1;
  localparam int unsigned IW    = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEPTH = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ACQ   = 3'd3;
  localparam logic [2:0] S_TOP   = 3'd4;

  // Memories and valid bits
  logic [LOCK_W-1:0] stack_mem [SLOTS];
  logic [DW-1:0]     depth_mem [TASKS];
  logic [TASKS-1:0]  dvalid_q;

  logic [LOCK_W-1:0] stk_rd_q;
  logic [DW-1:0]     dep_rd_q;
  logic              dv_rd_q;

  // Sequencer registers
  logic [2:0]        state_q, state_d;
  hloc_item_t        item_q, item_d;
  logic [SAW-1:0]    base_q, base_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic [IW-1:0]     idx_q, idx_d;

  // Result register
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic [DEPTH_OUT_W-1:0] res_depth_q, res_depth_d;
  logic [LOCK_W-1:0]      res_expect_q, res_expect_d;

  // Memory controls
  logic [SAW-1:0] stk_ra;
  logic [SAW-1:0] stk_wa;
  logic           stk_we;
  logic [TW-1:0]  dep_ra;
  logic [TW-1:0]  tidx_q;
  logic           dep_we;
  logic [DW-1:0]  dep_wd;
  logic [SAW-1:0] base_c;
  logic [DW-1:0]  cur_depth;
  logic           slot_free;
  logic           out_load;
  logic           scan_more;

  assign tidx_q    = TW'(item_q.task_id);
  assign base_c    = SAW'(tidx_q) * SAW'(MAX_HELD);
  assign cur_depth = dv_rd_q ? dep_rd_q : '0;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign scan_more = (DW1'(idx_q) + DW1'(1)) < DW1'(depth_q);

  // Step the sequencer
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    base_d       = base_q;
    depth_d      = depth_q;
    idx_d        = idx_q;
    q_pop_o      = 1'b0;
    stk_ra       = base_q + SAW'(idx_q);
    stk_wa       = base_q + SAW'(depth_q);
    stk_we       = 1'b0;
    dep_ra       = TW'(q_item_i.task_id);
    dep_we       = 1'b0;
    dep_wd       = depth_q;
    out_load     = 1'b0;
    res_status_d = res_status_q;
    res_depth_d  = res_depth_q;
    res_expect_d = res_expect_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && slot_free) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          if (q_item_i.ignored) begin
            out_load     = 1'b1;
            res_status_d = ST_IGNORED;
            res_depth_d  = '0;
            res_expect_d = '0;
          end else begin
            state_d = S_DEPTH;
          end
        end
      end
      S_DEPTH: begin
        depth_d = cur_depth;
        base_d  = base_c;
        idx_d   = '0;
        if (item_q.mode == MODE_ACQUIRE) begin
          stk_ra  = base_c;
          state_d = (cur_depth == '0) ? S_ACQ : S_SCAN;
        end else begin
          stk_ra = base_c + SAW'(cur_depth - DW'(1));
          if (cur_depth == '0) begin
            out_load     = 1'b1;
            res_status_d = ST_EMPTY;
            res_depth_d  = '0;
            res_expect_d = '0;
            state_d      = S_IDLE;
          end else begin
            state_d = S_TOP;
          end
        end
      end
      S_SCAN: begin
        if (stk_rd_q == item_q.lock_id) begin
          out_load     = 1'b1;
          res_status_d = ST_DUP;
          res_depth_d  = DEPTH_OUT_W'(depth_q);
          res_expect_d = '0;
          state_d      = S_IDLE;
        end else if (scan_more) begin
          idx_d  = idx_q + IW'(1);
          stk_ra = base_q + SAW'(idx_q) + SAW'(1);
        end else begin
          state_d = S_ACQ;
        end
      end
      S_ACQ: begin
        out_load     = 1'b1;
        res_expect_d = '0;
        state_d      = S_IDLE;
        if (32'(depth_q) >= MAX_HELD) begin
          res_status_d = ST_OVERFLOW;
          res_depth_d  = DEPTH_OUT_W'(depth_q);
        end else begin
          stk_we       = 1'b1;
          dep_we       = 1'b1;
          dep_wd       = depth_q + DW'(1);
          res_status_d = ST_OK;
          res_depth_d  = DEPTH_OUT_W'(depth_q + DW'(1));
        end
      end
      S_TOP: begin
        out_load = 1'b1;
        state_d  = S_IDLE;
        if (stk_rd_q != item_q.lock_id) begin
          res_status_d = ST_ORDER;
          res_depth_d  = DEPTH_OUT_W'(depth_q);
          res_expect_d = stk_rd_q;
        end else begin
          dep_we       = 1'b1;
          dep_wd       = depth_q - DW'(1);
          res_status_d = ST_OK;
          res_depth_d  = DEPTH_OUT_W'(depth_q - DW'(1));
          res_expect_d = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dvalid_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (dep_we) begin
        dvalid_q[tidx_q] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    base_q       <= base_d;
    depth_q      <= depth_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_depth_q  <= res_depth_d;
    res_expect_q <= res_expect_d;
  end

  // Stack memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= item_q.lock_id;
    end
    stk_rd_q <= stack_mem[stk_ra];
  end

  // Depth memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      depth_mem[tidx_q] <= dep_wd;
    end
    dep_rd_q <= depth_mem[dep_ra];
    dv_rd_q  <= dvalid_q[dep_ra];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {res_expect_q, res_depth_q, res_status_q};

  // Checks
  `HLOC_ASSERT_IMPL(a_load_free, out_load, !out_valid_q || m_axis_tready_i, "result overwritten")
  `HLOC_ASSERT_IMPL(a_scan_idx, state_q == S_SCAN, DW1'(idx_q) < DW1'(depth_q), "scan past depth")
  `HLOC_ASSERT_IMPL(a_depth_max, dep_we, 32'(dep_wd) <= MAX_HELD, "depth above stack size")
  `HLOC_ASSERT_NEXT(a_done_out, (state_q != S_IDLE) && (state_d == S_IDLE), out_valid_q, "no result")

endmodule

[hdl/held_lock_order_checker.sv]
// Top level of the held lock order checker.
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tdata 40 bits, tuser mode
//  m_axis    out        m_axis_tvalid/tready       tdata 40 bits
//  cfg       in         cfg_valid_i/cfg_ready_o    cfg_data_i check_enable
//
// An input transaction enters a two-entry queue; the back end then takes one item at a time.
// Ignored items finish in the idle state; releases read the depth, then check the top entry
// unless nothing is held; acquires read the depth, then scan the held entries one by one
// through the single stack memory read port before the push.
// Reset clears the depth valid bits at once; no clearing pass is needed.
// A stalled result holds in the output register while the queue keeps accepting until it is full.
`timescale 1ns / 1ps

module held_lock_order_checker import hloc_pkg::*; #(
  parameter int unsigned MAX_HELD = MAX_HELD_DEF,
  parameter int unsigned TASKS    = TASKS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: task_id[3:0], task_valid[4], lock_id[36:5], tracked[37], zero pad[39:38]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: mode[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: status[2:0], depth_after[7:3], expected_lock[39:8]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);

  logic       q_full;
  logic       q_push;
  hloc_item_t q_in_item;
  logic       q_valid;
  logic       q_pop;
  hloc_item_t q_out_item;

  // Accept and classify
  hloc_front #(
    .TASKS (TASKS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in_item)
  );

  // Decouple front and back end
  hloc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  // Check against the held stacks
  hloc_back #(
    .MAX_HELD (MAX_HELD),
    .TASKS    (TASKS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_out_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the held lock order checker.
`timescale 1ns / 1ps

module tb_top;
  import hloc_pkg::*;

  localparam int unsigned STIM_VIEW  = 0;  // lock tables as the stimulus plans them
  localparam int unsigned DUT_VIEW   = 1;  // lock tables as the block should hold them
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned TAIL_WAIT  = 40;

  typedef struct packed {
    logic                 mode;
    logic [TASK_ID_W-1:0] task_id;
    logic                 task_valid;
    logic [LOCK_W-1:0]    lock_id;
    logic                 tracked;
  } lock_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [LOCK_W-1:0]      top_lock;
  } lock_verdict_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i    = 1'b0;

  // Two copies of the per-task lock stacks: one steers stimulus, one predicts
  logic [LOCK_W-1:0]      held_locks [2][TASKS_DEF][MAX_HELD_DEF];
  logic [DEPTH_OUT_W-1:0] held_count [2][TASKS_DEF];
  logic                   enable_planned = 1'b0;
  logic                   enable_live    = 1'b0;

  lock_op_t      ops_to_send [$];
  lock_verdict_t verdicts_due [$];
  lock_op_t      op_on_bus;
  int unsigned   ops_queued  = 0;
  int unsigned   ops_taken   = 0;
  int unsigned   send_gap    = 0;
  int unsigned   ready_hold  = 0;
  int unsigned   quiet_count = 0;
  int unsigned   n_errors    = 0;
  logic          idle_on     = 1'b1;

  held_lock_order_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one acquire or release to a view of the lock stacks, return its verdict
  function automatic lock_verdict_t apply_lock_op(input int unsigned view, input logic enable,
                                                  input lock_op_t op);
    lock_verdict_t          v;
    logic [DEPTH_OUT_W-1:0] d;
    logic [LOCK_W-1:0]      top;
    logic                   dup;
    v   = '0;
    dup = 1'b0;
    d   = held_count[view][op.task_id];
    if (!enable || !op.tracked || !op.task_valid) begin
      v.status = ST_IGNORED;
    end else if (op.mode == MODE_ACQUIRE) begin
      for (int i = 0; i < MAX_HELD_DEF; i++) begin
        if (i < d && held_locks[view][op.task_id][i] == op.lock_id) dup = 1'b1;
      end
      v.depth = d;
      if (dup) begin
        v.status = ST_DUP;
      end else if (d >= MAX_HELD_DEF) begin
        v.status = ST_OVERFLOW;
      end else begin
        held_locks[view][op.task_id][d] = op.lock_id;
        held_count[view][op.task_id]    = d + 5'd1;
        v.status = ST_OK;
        v.depth  = d + 5'd1;
      end
    end else if (d == 0) begin
      v.status = ST_EMPTY;
    end else begin
      top = held_locks[view][op.task_id][d - 5'd1];
      if (top != op.lock_id) begin
        v.status   = ST_ORDER;
        v.depth    = d;
        v.top_lock = top;
      end else begin
        held_count[view][op.task_id] = d - 5'd1;
        v.status = ST_OK;
        v.depth  = d - 5'd1;
      end
    end
    return v;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // Queue one item and advance the planning view so later items fit the stacks
  task automatic queue_op(input logic mode, input int unsigned task_idx, input logic task_valid,
                          input logic [LOCK_W-1:0] lock_id, input logic tracked);
    lock_op_t      op;
    lock_verdict_t unused;
    op.mode       = mode;
    op.task_id    = task_idx[TASK_ID_W-1:0];
    op.task_valid = task_valid;
    op.lock_id    = lock_id;
    op.tracked    = tracked;
    unused = apply_lock_op(STIM_VIEW, enable_planned, op);
    ops_to_send.push_back(op);
    ops_queued++;
  endtask

  // Build random traffic: mostly well-nested acquire/release, some broken or ignored items
  task automatic queue_random_ops(input int unsigned count);
    int unsigned            t;
    int unsigned            r;
    logic [DEPTH_OUT_W-1:0] d;
    logic [LOCK_W-1:0]      lk;
    for (int n = 0; n < count; n++) begin
      t  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, TASKS_DEF - 1);
      d  = held_count[STIM_VIEW][t];
      r  = $urandom_range(0, 99);
      lk = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);
      if (r < 80) begin
        // well-formed: push a fresh lock or pop the top one
        if (d == 0 || (d < MAX_HELD_DEF && $urandom_range(0, 9) < 6) ||
            (d == MAX_HELD_DEF && $urandom_range(0, 9) < 3)) begin
          queue_op(MODE_ACQUIRE, t, 1'b1, lk, 1'b1);
        end else begin
          queue_op(MODE_RELEASE, t, 1'b1, held_locks[STIM_VIEW][t][d - 5'd1], 1'b1);
        end
      end else if (r < 88) begin
        // re-acquire something already held
        if (d > 0) lk = held_locks[STIM_VIEW][t][$urandom_range(0, d - 1)];
        queue_op(MODE_ACQUIRE, t, 1'b1, lk, 1'b1);
      end else if (r < 94) begin
        // release out of order, or with nothing held
        if (d > 1) lk = held_locks[STIM_VIEW][t][$urandom_range(0, d - 2)];
        queue_op(MODE_RELEASE, t, 1'b1, lk, 1'b1);
      end else begin
        // untracked site or no current task
        r = $urandom_range(0, 2);
        queue_op(1'($urandom_range(0, 1)), t, r == 1, lk, r == 2);
      end
    end
  endtask

  // Hold until every queued item was taken and every result has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (ops_taken != ops_queued || verdicts_due.size() != 0);
  endtask

  task automatic write_check_enable(input logic value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    enable_live    = value;
    enable_planned = value;
    cfg_valid_i   <= 1'b0;
  endtask

  // Input driver: hold the transaction until taken, then idle or send the next one
  always @(posedge clk_i) begin : op_driver
    lock_verdict_t v;
    if (s_axis_tvalid && s_axis_tready) begin
      v = apply_lock_op(DUT_VIEW, enable_live, op_on_bus);
      verdicts_due.push_back(v);
      ops_taken++;
    end
    if (s_axis_tvalid && !s_axis_tready) begin
      // hold the current transaction
    end else if (send_gap > 0) begin
      send_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (ops_to_send.size() > 0) begin
      op_on_bus      = ops_to_send.pop_front();
      s_axis_tdata  <= {2'b00, op_on_bus.tracked, op_on_bus.lock_id,
                        op_on_bus.task_valid, op_on_bus.task_id};
      s_axis_tuser  <= op_on_bus.mode;
      s_axis_tvalid <= 1'b1;
      send_gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Result monitor: compare each result with the oldest prediction, stall at random
  always @(posedge clk_i) begin : verdict_monitor
    lock_verdict_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("result 0x%h arrived with no prediction pending", m_axis_tdata);
        n_errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (m_axis_tdata[2:0] != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
          n_errors++;
        end
        if (m_axis_tdata[7:3] != want.depth) begin
          $error("depth_after: expected %0d, got %0d", want.depth, m_axis_tdata[7:3]);
          n_errors++;
        end
        if (m_axis_tdata[39:8] != want.top_lock) begin
          $error("expected_lock: expected 0x%h, got 0x%h", want.top_lock, m_axis_tdata[39:8]);
          n_errors++;
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      ready_hold = pick_idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_MAX) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    for (int t = 0; t < TASKS_DEF; t++) begin
      held_count[STIM_VIEW][t] = '0;
      held_count[DUT_VIEW][t]  = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // checking off: everything is ignored
    write_check_enable(1'b0);
    queue_op(MODE_ACQUIRE, 0, 1'b1, 32'h0000_0001, 1'b1);
    queue_op(MODE_RELEASE, 0, 1'b1, 32'h0000_0001, 1'b1);
    queue_random_ops(6);
    wait_drained();

    // checking on: directed corner cases
    write_check_enable(1'b1);
    queue_op(MODE_ACQUIRE, 0, 1'b1, 32'h0000_0000, 1'b1);
    queue_op(MODE_ACQUIRE, 0, 1'b1, 32'hFFFF_FFFF, 1'b1);
    queue_op(MODE_ACQUIRE, 0, 1'b1, 32'h0000_0000, 1'b1);  // duplicate
    queue_op(MODE_RELEASE, 0, 1'b1, 32'h0000_0000, 1'b1);  // not on top
    queue_op(MODE_RELEASE, 0, 1'b1, 32'hFFFF_FFFF, 1'b1);
    queue_op(MODE_RELEASE, 0, 1'b1, 32'h0000_0000, 1'b1);
    queue_op(MODE_RELEASE, 0, 1'b1, 32'h0000_0000, 1'b1);  // nothing held
    queue_op(MODE_ACQUIRE, 3, 1'b1, 32'h1234_5678, 1'b0);  // untracked
    queue_op(MODE_RELEASE, 3, 1'b0, 32'h1234_5678, 1'b1);  // no current task
    for (int i = 0; i < MAX_HELD_DEF; i++) begin
      queue_op(MODE_ACQUIRE, TASKS_DEF - 1, 1'b1, 32'hA5A5_0000 + i, 1'b1);
    end
    queue_op(MODE_ACQUIRE, TASKS_DEF - 1, 1'b1, 32'h0BAD_F00D, 1'b1);  // full stack
    queue_op(MODE_ACQUIRE, TASKS_DEF - 1, 1'b1, 32'hA5A5_0007, 1'b1);  // full and duplicate
    wait_drained();

    // random traffic, with a full drain in the middle
    queue_random_ops(130);
    wait_drained();
    queue_random_ops(130);
    wait_drained();

    // back-to-back stretch with no idling on either side
    idle_on = 1'b0;
    queue_random_ops(100);
    wait_drained();
    idle_on = 1'b1;

    // checking off again while stacks are populated
    write_check_enable(1'b0);
    queue_random_ops(40);
    wait_drained();

    write_check_enable(1'b1);
    queue_random_ops(220);
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
